// ----- rtl/csrc_pkg.sv -----
`timescale 1ns / 1ps

package csrc_pkg;

    // Default coordinate width of the collision datapath
    localparam int COORD_BITS_DEF = 16;

endpackage

// ----- rtl/csrc_div.sv -----
`timescale 1ns / 1ps

// Pipelined restoring divider: one quotient bit per stage, QUO_W stages.
// The quotient must fit QUO_W bits; a zero divisor gives a meaningless result.
// Only payload flows through here, so the stages carry no reset.
module csrc_div
    import csrc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int NUM_W      = 3 * COORD_BITS + 1,
    parameter int DEN_W      = 2 * COORD_BITS + 1,
    parameter int QUO_W      = COORD_BITS
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    logic [NUM_W-1:0] rem_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++)
        begin : g_stage
            localparam int SH = QUO_W - 1 - k;
            logic [NUM_W-1:0] rem_in;
            logic [DEN_W-1:0] den_in;
            logic [QUO_W-1:0] quo_in;
            logic [NUM_W-1:0] shifted;
            logic             ge;
            logic [NUM_W-1:0] rem_next;
            logic [QUO_W-1:0] quo_next;

            if (k == 0)
            begin : g_first
                assign rem_in = num;
                assign den_in = den;
                assign quo_in = '0;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign den_in = den_reg[k-1];
                assign quo_in = quo_reg[k-1];
            end

            // Trial subtract of the divisor aligned to this quotient bit
            always_comb
            begin
                shifted  = NUM_W'(den_in) << SH;
                ge       = (rem_in >= shifted);
                rem_next = ge ? (rem_in - shifted) : rem_in;
                quo_next = (quo_in << 1) | QUO_W'(ge);
            end

            // Advance the stage on enable
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in;
                    quo_reg[k] <= quo_next;
                end
            end
        end
    endgenerate

    assign quo = quo_reg[QUO_W-1];

endmodule

// ----- rtl/circle_segment_rect_collision.sv -----
`timescale 1ns / 1ps

// Channel  Dir  Handshake          Payload
// s        in   s_tvalid/s_tready  s_tdata, s_tuser = operation
// m        out  m_tvalid/m_tready  m_tdata = hit
//
// A fully pipelined datapath: one item per cycle unless stalled; its depth is set
// mostly by the bit-per-stage divider of the segment projection.
// All stages advance together when the output register is empty or taken;
// a stall freezes the whole pipeline, losing and repeating nothing.
// Reset clears only the valid bits.
module circle_segment_rect_collision
    import csrc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // circle_x, circle_y, radius, point_a_x, point_a_y, point_b_x, point_b_y
    input  logic [((7*COORD_BITS-1+7)/8)*8-1:0]     s_tdata,
    // operation
    input  logic                                    s_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // hit
    output logic [7:0]                              m_tdata
);

    localparam int C     = COORD_BITS;
    localparam int D     = C + 1;
    localparam int SQ_W  = 2 * D;
    localparam int LEN_W = 2 * C + 1;
    localparam int T_W   = 2 * C + 2;
    localparam int MAG_W = C;
    localparam int NUM_W = LEN_W + MAG_W;
    localparam int QUO_W = C;
    localparam int RR_W  = 2 * (C - 1);

    logic en;

    // ---------------- stage 1: register fields and differences
    logic                v1_reg, op1_reg;
    logic signed [C-1:0] cx1_reg, cy1_reg, ax1_reg, ay1_reg, bx1_reg, by1_reg;
    logic [C-2:0]        r1_reg;
    logic signed [D-1:0] lx1_reg, ly1_reg, vx1_reg, vy1_reg;

    logic signed [C-1:0] in_cx, in_cy, in_ax, in_ay, in_bx, in_by;
    logic [C-2:0]        in_r;
    logic signed [D-1:0] e_cx, e_cy, e_ax, e_ay, e_bx, e_by;

    assign in_cx = s_tdata[C-1:0];
    assign in_cy = s_tdata[2*C-1:C];
    assign in_r  = s_tdata[3*C-2:2*C];
    assign in_ax = s_tdata[4*C-2:3*C-1];
    assign in_ay = s_tdata[5*C-2:4*C-1];
    assign in_bx = s_tdata[6*C-2:5*C-1];
    assign in_by = s_tdata[7*C-2:6*C-1];

    assign e_cx = in_cx;
    assign e_cy = in_cy;
    assign e_ax = in_ax;
    assign e_ay = in_ay;
    assign e_bx = in_bx;
    assign e_by = in_by;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg <= s_tuser;
            cx1_reg <= in_cx;
            cy1_reg <= in_cy;
            r1_reg  <= in_r;
            ax1_reg <= in_ax;
            ay1_reg <= in_ay;
            bx1_reg <= in_bx;
            by1_reg <= in_by;
            lx1_reg <= e_bx - e_ax;
            ly1_reg <= e_by - e_ay;
            vx1_reg <= e_ax - e_cx;
            vy1_reg <= e_ay - e_cy;
        end
    end

    // ---------------- stage 2: segment products, rectangle distances
    logic                 v2_reg, op2_reg, neg_x2_reg, neg_y2_reg, in2_reg;
    logic signed [C-1:0]  cx2_reg, cy2_reg, ax2_reg, ay2_reg;
    logic [C-2:0]         r2_reg;
    logic signed [SQ_W-1:0] llx2_reg, lly2_reg, pvx2_reg, pvy2_reg;
    logic [MAG_W-1:0]     mag_x2_reg, mag_y2_reg;
    logic signed [D-1:0]  tdx2_reg, tdy2_reg, bdy2_reg, ldx2_reg, ldy2_reg, rdx2_reg;

    logic signed [D-1:0]  s1_cx, s1_cy, s1_ax, s1_ay, s1_bx, s1_by, s1_r;
    logic signed [D-1:0]  lo_x, hi_x, lo_y, hi_y, cl_x, cl_y;
    logic signed [D-1:0]  pp_x, pp_y, mm_x, mm_y;
    logic                 inside_pp, inside_mm;
    logic signed [D-1:0]  abs_lx, abs_ly;

    always_comb
    begin
        s1_cx = cx1_reg;
        s1_cy = cy1_reg;
        s1_ax = ax1_reg;
        s1_ay = ay1_reg;
        s1_bx = bx1_reg;
        s1_by = by1_reg;
        s1_r  = $signed({2'b00, r1_reg});
        lo_x  = (s1_ax < s1_bx) ? s1_ax : s1_bx;
        hi_x  = (s1_ax < s1_bx) ? s1_bx : s1_ax;
        lo_y  = (s1_ay < s1_by) ? s1_ay : s1_by;
        hi_y  = (s1_ay < s1_by) ? s1_by : s1_ay;
        cl_x  = (s1_cx < lo_x) ? lo_x : ((s1_cx > hi_x) ? hi_x : s1_cx);
        cl_y  = (s1_cy < lo_y) ? lo_y : ((s1_cy > hi_y) ? hi_y : s1_cy);
        pp_x  = s1_cx + s1_r;
        pp_y  = s1_cy + s1_r;
        mm_x  = s1_cx - s1_r;
        mm_y  = s1_cy - s1_r;
        // Half-open containment against the corners as given
        inside_pp = (pp_x >= s1_ax) && (pp_x < s1_bx) && (pp_y >= s1_ay) && (pp_y < s1_by);
        inside_mm = (mm_x >= s1_ax) && (mm_x < s1_bx) && (mm_y >= s1_ay) && (mm_y < s1_by);
        abs_lx = lx1_reg[D-1] ? -lx1_reg : lx1_reg;
        abs_ly = ly1_reg[D-1] ? -ly1_reg : ly1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op2_reg    <= op1_reg;
            cx2_reg    <= cx1_reg;
            cy2_reg    <= cy1_reg;
            ax2_reg    <= ax1_reg;
            ay2_reg    <= ay1_reg;
            r2_reg     <= r1_reg;
            llx2_reg   <= lx1_reg * lx1_reg;
            lly2_reg   <= ly1_reg * ly1_reg;
            pvx2_reg   <= vx1_reg * lx1_reg;
            pvy2_reg   <= vy1_reg * ly1_reg;
            neg_x2_reg <= lx1_reg[D-1];
            neg_y2_reg <= ly1_reg[D-1];
            mag_x2_reg <= abs_lx[MAG_W-1:0];
            mag_y2_reg <= abs_ly[MAG_W-1:0];
            tdx2_reg   <= cl_x - s1_cx;
            tdy2_reg   <= s1_ay - s1_cy;
            bdy2_reg   <= s1_by - s1_cy;
            ldx2_reg   <= s1_ax - s1_cx;
            ldy2_reg   <= cl_y - s1_cy;
            rdx2_reg   <= s1_bx - s1_cx;
            in2_reg    <= inside_pp || inside_mm;
        end
    end

    // ---------------- stage 3: length, clamped projection, rectangle squares
    logic                 v3_reg, op3_reg, neg_x3_reg, neg_y3_reg, in3_reg;
    logic signed [C-1:0]  cx3_reg, cy3_reg, ax3_reg, ay3_reg;
    logic [C-2:0]         r3_reg;
    logic [LEN_W-1:0]     len3_reg, tc3_reg;
    logic [MAG_W-1:0]     mag_x3_reg, mag_y3_reg;
    logic [RR_W-1:0]      rr3_reg;
    logic signed [SQ_W-1:0] sq_tdx3_reg, sq_tdy3_reg, sq_bdy3_reg;
    logic signed [SQ_W-1:0] sq_ldx3_reg, sq_ldy3_reg, sq_rdx3_reg;

    logic signed [T_W-1:0] t_raw, len_s;
    logic [LEN_W-1:0]      t_clamp;

    always_comb
    begin
        len_s = T_W'(llx2_reg + lly2_reg);
        t_raw = T_W'(-(pvx2_reg + pvy2_reg));
        // Clamp the projection to the segment
        if (t_raw < 0)
            t_clamp = '0;
        else if (t_raw > len_s)
            t_clamp = len_s[LEN_W-1:0];
        else
            t_clamp = t_raw[LEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op3_reg     <= op2_reg;
            cx3_reg     <= cx2_reg;
            cy3_reg     <= cy2_reg;
            ax3_reg     <= ax2_reg;
            ay3_reg     <= ay2_reg;
            r3_reg      <= r2_reg;
            neg_x3_reg  <= neg_x2_reg;
            neg_y3_reg  <= neg_y2_reg;
            mag_x3_reg  <= mag_x2_reg;
            mag_y3_reg  <= mag_y2_reg;
            len3_reg    <= len_s[LEN_W-1:0];
            tc3_reg     <= t_clamp;
            in3_reg     <= in2_reg;
            rr3_reg     <= r2_reg * r2_reg;
            sq_tdx3_reg <= tdx2_reg * tdx2_reg;
            sq_tdy3_reg <= tdy2_reg * tdy2_reg;
            sq_bdy3_reg <= bdy2_reg * bdy2_reg;
            sq_ldx3_reg <= ldx2_reg * ldx2_reg;
            sq_ldy3_reg <= ldy2_reg * ldy2_reg;
            sq_rdx3_reg <= rdx2_reg * rdx2_reg;
        end
    end

    // ---------------- stage 4: projection numerators, rectangle result
    logic                 v4_reg, op4_reg, neg_x4_reg, neg_y4_reg, zero4_reg, rect4_reg;
    logic signed [C-1:0]  cx4_reg, cy4_reg, ax4_reg, ay4_reg;
    logic [RR_W-1:0]      rr4_reg;
    logic [LEN_W-1:0]     len4_reg;
    logic [NUM_W-1:0]     nx4_reg, ny4_reg;

    logic [SQ_W:0] d_top, d_bot, d_left, d_right, rr_ext;
    logic          edge_hit;

    always_comb
    begin
        rr_ext   = (SQ_W + 1)'(rr3_reg);
        d_top    = (SQ_W + 1)'($unsigned(sq_tdx3_reg)) + (SQ_W + 1)'($unsigned(sq_tdy3_reg));
        d_bot    = (SQ_W + 1)'($unsigned(sq_tdx3_reg)) + (SQ_W + 1)'($unsigned(sq_bdy3_reg));
        d_left   = (SQ_W + 1)'($unsigned(sq_ldx3_reg)) + (SQ_W + 1)'($unsigned(sq_ldy3_reg));
        d_right  = (SQ_W + 1)'($unsigned(sq_rdx3_reg)) + (SQ_W + 1)'($unsigned(sq_ldy3_reg));
        edge_hit = (d_top < rr_ext) || (d_bot < rr_ext) ||
                   (d_left < rr_ext) || (d_right < rr_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op4_reg    <= op3_reg;
            cx4_reg    <= cx3_reg;
            cy4_reg    <= cy3_reg;
            ax4_reg    <= ax3_reg;
            ay4_reg    <= ay3_reg;
            rr4_reg    <= rr3_reg;
            neg_x4_reg <= neg_x3_reg;
            neg_y4_reg <= neg_y3_reg;
            zero4_reg  <= (len3_reg == '0);
            len4_reg   <= len3_reg;
            nx4_reg    <= tc3_reg * mag_x3_reg;
            ny4_reg    <= tc3_reg * mag_y3_reg;
            rect4_reg  <= in3_reg || edge_hit;
        end
    end

    // ---------------- divider lanes with matching side delay
    logic [QUO_W-1:0] qx, qy;

    csrc_div #(
        .COORD_BITS (COORD_BITS),
        .NUM_W      (NUM_W),
        .DEN_W      (LEN_W),
        .QUO_W      (QUO_W)
    ) u_div_x (
        .clk   (clk),
        .en    (en),
        .num   (nx4_reg),
        .den   (len4_reg),
        .quo   (qx)
    );

    csrc_div #(
        .COORD_BITS (COORD_BITS),
        .NUM_W      (NUM_W),
        .DEN_W      (LEN_W),
        .QUO_W      (QUO_W)
    ) u_div_y (
        .clk   (clk),
        .en    (en),
        .num   (ny4_reg),
        .den   (len4_reg),
        .quo   (qy)
    );

    logic                dv_reg    [QUO_W];
    logic                dop_reg   [QUO_W];
    logic                dnx_reg   [QUO_W];
    logic                dny_reg   [QUO_W];
    logic                dzero_reg [QUO_W];
    logic                drect_reg [QUO_W];
    logic signed [C-1:0] dcx_reg   [QUO_W];
    logic signed [C-1:0] dcy_reg   [QUO_W];
    logic signed [C-1:0] dax_reg   [QUO_W];
    logic signed [C-1:0] day_reg   [QUO_W];
    logic [RR_W-1:0]     drr_reg   [QUO_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUO_W; i++)
                dv_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            dv_reg[0] <= v4_reg;
            for (int i = 1; i < QUO_W; i++)
                dv_reg[i] <= dv_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dop_reg[0]   <= op4_reg;
            dnx_reg[0]   <= neg_x4_reg;
            dny_reg[0]   <= neg_y4_reg;
            dzero_reg[0] <= zero4_reg;
            drect_reg[0] <= rect4_reg;
            dcx_reg[0]   <= cx4_reg;
            dcy_reg[0]   <= cy4_reg;
            dax_reg[0]   <= ax4_reg;
            day_reg[0]   <= ay4_reg;
            drr_reg[0]   <= rr4_reg;
            for (int i = 1; i < QUO_W; i++)
            begin
                dop_reg[i]   <= dop_reg[i-1];
                dnx_reg[i]   <= dnx_reg[i-1];
                dny_reg[i]   <= dny_reg[i-1];
                dzero_reg[i] <= dzero_reg[i-1];
                drect_reg[i] <= drect_reg[i-1];
                dcx_reg[i]   <= dcx_reg[i-1];
                dcy_reg[i]   <= dcy_reg[i-1];
                dax_reg[i]   <= dax_reg[i-1];
                day_reg[i]   <= day_reg[i-1];
                drr_reg[i]   <= drr_reg[i-1];
            end
        end
    end

    // ---------------- stage 5: closest point offsets
    localparam int L = QUO_W - 1;

    logic                v5_reg, op5_reg, rect5_reg;
    logic [RR_W-1:0]     rr5_reg;
    logic signed [D:0]   dx5_reg, dy5_reg;

    logic signed [D:0]   qx_s, qy_s, ax_s, ay_s, cx_s, cy_s, px_s, py_s;

    always_comb
    begin
        // A zero-length segment keeps its start point
        qx_s = dzero_reg[L] ? '0 : $signed({2'b00, qx});
        qy_s = dzero_reg[L] ? '0 : $signed({2'b00, qy});
        ax_s = dax_reg[L];
        ay_s = day_reg[L];
        cx_s = dcx_reg[L];
        cy_s = dcy_reg[L];
        px_s = dnx_reg[L] ? (ax_s - qx_s) : (ax_s + qx_s);
        py_s = dny_reg[L] ? (ay_s - qy_s) : (ay_s + qy_s);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= dv_reg[L];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op5_reg   <= dop_reg[L];
            rect5_reg <= drect_reg[L];
            rr5_reg   <= drr_reg[L];
            dx5_reg   <= px_s - cx_s;
            dy5_reg   <= py_s - cy_s;
        end
    end

    // ---------------- stage 6: squared distance
    logic                  v6_reg, op6_reg, rect6_reg;
    logic [RR_W-1:0]       rr6_reg;
    logic [SQ_W+2:0]       dist6_reg;
    logic signed [SQ_W+1:0] sqx, sqy;

    always_comb
    begin
        sqx = dx5_reg * dx5_reg;
        sqy = dy5_reg * dy5_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (en)
            v6_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op6_reg   <= op5_reg;
            rect6_reg <= rect5_reg;
            rr6_reg   <= rr5_reg;
            dist6_reg <= (SQ_W + 3)'($unsigned(sqx)) + (SQ_W + 3)'($unsigned(sqy));
        end
    end

    // ---------------- stage 7: output register
    logic out_v_reg, hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= v6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            hit_reg <= op6_reg ? rect6_reg : (dist6_reg < (SQ_W + 3)'(rr6_reg));
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {7'b0000000, hit_reg};

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import csrc_pkg::*;

    localparam int CB      = COORD_BITS_DEF;
    localparam int DW      = ((7*CB-1+7)/8)*8;
    localparam int LATENCY = CB + 7;
    localparam int N_RAND  = 1850;

    localparam logic OP_SEGMENT = 1'b0;
    localparam logic OP_RECT    = 1'b1;

    typedef struct packed {
        logic                 op;
        logic signed [CB-1:0] cx;
        logic signed [CB-1:0] cy;
        logic [CB-2:0]        r;
        logic signed [CB-1:0] ax;
        logic signed [CB-1:0] ay;
        logic signed [CB-1:0] bx;
        logic signed [CB-1:0] by;
    } query_t;

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [DW-1:0] s_tdata;
    logic          s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [7:0]    m_tdata;

    query_t     pending_queries[$];
    logic [7:0] expected_hits[$];
    int         n_errors;
    int         n_hits;
    int         n_results;

    circle_segment_rect_collision u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Exact segment test in wide signed arithmetic
    function automatic bit segment_touch(longint cx, longint cy, longint r,
                                         longint ax, longint ay,
                                         longint bx, longint by);
        longint lx;
        longint ly;
        longint len2;
        longint proj;
        longint px;
        longint py;
        longint dx;
        longint dy;
        logic signed [127:0] num;
        logic signed [127:0] quo;
        lx   = bx - ax;
        ly   = by - ay;
        len2 = lx * lx + ly * ly;
        proj = -((ax - cx) * lx + (ay - cy) * ly);
        if (proj < 0)
            proj = 0;
        else if (proj > len2)
            proj = len2;
        px = ax;
        py = ay;
        if (len2 != 0)
        begin
            // SV signed division truncates toward zero
            num = 128'(signed'(proj)) * 128'(signed'(lx));
            quo = num / 128'(signed'(len2));
            px  = px + longint'(quo);
            num = 128'(signed'(proj)) * 128'(signed'(ly));
            quo = num / 128'(signed'(len2));
            py  = py + longint'(quo);
        end
        dx = px - cx;
        dy = py - cy;
        return (dx * dx + dy * dy) < (r * r);
    endfunction

    function automatic bit in_rect(longint x, longint y, longint x1, longint y1,
                                   longint x2, longint y2);
        return x >= x1 && x < x2 && y >= y1 && y < y2;
    endfunction

    function automatic bit collision_hit(query_t q);
        longint cx;
        longint cy;
        longint r;
        longint x1;
        longint y1;
        longint x2;
        longint y2;
        cx = q.cx; cy = q.cy; r = longint'({1'b0, q.r});
        x1 = q.ax; y1 = q.ay; x2 = q.bx; y2 = q.by;
        if (q.op == OP_SEGMENT)
            return segment_touch(cx, cy, r, x1, y1, x2, y2);
        if (in_rect(cx + r, cy + r, x1, y1, x2, y2) ||
            in_rect(cx - r, cy - r, x1, y1, x2, y2))
            return 1'b1;
        return segment_touch(cx, cy, r, x1, y1, x2, y1) ||
               segment_touch(cx, cy, r, x1, y1, x1, y2) ||
               segment_touch(cx, cy, r, x1, y2, x2, y2) ||
               segment_touch(cx, cy, r, x2, y1, x2, y2);
    endfunction

    function automatic logic [DW-1:0] pack_query(query_t q);
        logic [DW-1:0] d;
        d = '0;
        d[0*CB +: CB]     = q.cx;
        d[1*CB +: CB]     = q.cy;
        d[2*CB +: CB-1]   = q.r;
        d[3*CB-1 +: CB]   = q.ax;
        d[4*CB-1 +: CB]   = q.ay;
        d[5*CB-1 +: CB]   = q.bx;
        d[6*CB-1 +: CB]   = q.by;
        return d;
    endfunction

    function automatic query_t make_query(logic op, int cx, int cy, int r,
                                          int ax, int ay, int bx, int by);
        query_t q;
        q.op = op; q.cx = CB'(cx); q.cy = CB'(cy); q.r = (CB-1)'(r);
        q.ax = CB'(ax); q.ay = CB'(ay); q.bx = CB'(bx); q.by = CB'(by);
        return q;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(0, 3))
            0: return int'($urandom_range(0, 65535)) - 32768;
            1: return int'($urandom_range(0, 400)) - 200;
            2: return ($urandom_range(0, 1) != 0) ? 32767 - int'($urandom_range(0, 50))
                                                  : -32768 + int'($urandom_range(0, 50));
            default: return int'($urandom_range(0, 8000)) - 4000;
        endcase
    endfunction

    // Random query, mostly near the circle so hits and misses both occur
    function automatic query_t rand_query();
        query_t q;
        int     cx;
        int     cy;
        int     span;
        q.op = 1'($urandom_range(0, 1));
        q.r  = ($urandom_range(0, 7) == 0) ? (CB-1)'($urandom_range(0, 32767))
                                           : (CB-1)'($urandom_range(0, 300));
        if ($urandom_range(0, 3) == 0)
        begin
            q.cx = CB'(rand_coord()); q.cy = CB'(rand_coord());
            q.ax = CB'(rand_coord()); q.ay = CB'(rand_coord());
            q.bx = CB'(rand_coord()); q.by = CB'(rand_coord());
        end
        else
        begin
            cx   = int'($urandom_range(0, 20000)) - 10000;
            cy   = int'($urandom_range(0, 20000)) - 10000;
            span = 2 * int'(q.r) + 20;
            q.cx = CB'(cx); q.cy = CB'(cy);
            q.ax = CB'(cx + int'($urandom_range(0, 2 * span)) - span);
            q.ay = CB'(cy + int'($urandom_range(0, 2 * span)) - span);
            q.bx = ($urandom_range(0, 9) == 0) ? q.ax
                   : CB'(cx + int'($urandom_range(0, 2 * span)) - span);
            q.by = ($urandom_range(0, 9) == 0) ? q.ay
                   : CB'(cy + int'($urandom_range(0, 2 * span)) - span);
        end
        return q;
    endfunction

    // Fill the stimulus queue: corner cases first, then random queries
    initial
    begin
        pending_queries.push_back(make_query(OP_SEGMENT, 0, 0, 10, -20, 5, 20, 5));
        pending_queries.push_back(make_query(OP_SEGMENT, 0, 0, 5, -20, 5, 20, 5));
        pending_queries.push_back(make_query(OP_SEGMENT, 0, 0, 10, 3, 4, 3, 4));
        pending_queries.push_back(make_query(OP_SEGMENT, 0, 0, 5, 3, 4, 3, 4));
        pending_queries.push_back(make_query(OP_SEGMENT, 0, 0, 0, 0, 0, 0, 0));
        pending_queries.push_back(make_query(OP_SEGMENT, 0, 0, 0, -5, 0, 5, 0));
        pending_queries.push_back(make_query(OP_SEGMENT, 100, 100, 50, 0, 0, 30, 30));
        pending_queries.push_back(make_query(OP_SEGMENT, -32768, -32768, 32767,
                                             32767, 32767, -32768, 32767));
        pending_queries.push_back(make_query(OP_SEGMENT, 32767, 32767, 32767,
                                             -32768, -32768, 32767, -32768));
        pending_queries.push_back(make_query(OP_SEGMENT, -32768, 32767, 32767,
                                             32767, -32768, -32768, -32768));
        pending_queries.push_back(make_query(OP_SEGMENT, 7, -3, 4, -9, 11, 13, -17));
        pending_queries.push_back(make_query(OP_RECT, 0, 0, 2, -10, -10, 10, 10));
        pending_queries.push_back(make_query(OP_RECT, 0, 0, 0, 0, 0, 10, 10));
        pending_queries.push_back(make_query(OP_RECT, 10, 10, 0, 0, 0, 10, 10));
        pending_queries.push_back(make_query(OP_RECT, 0, 0, 0, 10, 10, 0, 0));
        pending_queries.push_back(make_query(OP_RECT, 0, 0, 5, 10, 10, -10, -10));
        pending_queries.push_back(make_query(OP_RECT, 15, 5, 6, 0, 0, 10, 10));
        pending_queries.push_back(make_query(OP_RECT, 15, 5, 4, 0, 0, 10, 10));
        pending_queries.push_back(make_query(OP_RECT, 0, 0, 32767, -32768, -32768,
                                             32767, 32767));
        pending_queries.push_back(make_query(OP_RECT, -32768, -32768, 32767,
                                             32767, 32767, -32768, -32768));
        pending_queries.push_back(make_query(OP_RECT, 5, 5, 3, 0, 0, 0, 10));
        pending_queries.push_back(make_query(OP_RECT, 32767, 0, 1, 32767, -32768,
                                             -32768, 32767));
        for (int i = 0; i < N_RAND; i++)
            pending_queries.push_back(rand_query());
    end

    // Reset, then wait for the stream to drain
    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_queries.size() == 0 && !s_tvalid);
        wait (expected_hits.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        $display("Ran %0d queries (segment and rectangle, corners and random), %0d hits.",
                 n_results, n_hits);
        if (n_errors == 0 && expected_hits.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    // Driver: bursts of items separated by random gaps
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 4;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left > 0)
            begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_queries.size() > 0)
            begin
                query_t q;
                q = pending_queries.pop_front();
                expected_hits.push_back({7'd0, collision_hit(q)});
                s_tvalid <= 1'b1;
                s_tdata  <= pack_query(q);
                s_tuser  <= q.op;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver stall pattern, with one long hold-off to back up the pipeline
    int cycle_count;
    int hold_off;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            cycle_count <= 0;
            hold_off    <= 0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count == 400)
            begin
                hold_off <= 3 * LATENCY + 40;
                m_tready <= 1'b0;
            end
            else if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                m_tready <= 1'b0;
            end
            else if ((cycle_count / 300) % 2 == 0)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_hits.size() == 0)
            begin
                $display("%0t: unexpected result, actual %h", $time, m_tdata);
                n_errors <= n_errors + 1;
            end
            else
            begin
                logic [7:0] want;
                want = expected_hits.pop_front();
                n_results <= n_results + 1;
                n_hits    <= n_hits + want[0];
                if (m_tdata !== want)
                begin
                    $display("%0t: hit mismatch, expected %h, actual %h",
                             $time, want, m_tdata);
                    n_errors <= n_errors + 1;
                end
            end
        end
    end

endmodule

// ----- files.f -----
rtl/csrc_pkg.sv
rtl/csrc_div.sv
rtl/circle_segment_rect_collision.sv
verif/tb.sv
